>>> rtl/ddo_pkg.sv
// Shared types, constants and helper functions for the differential-drive odometry block.
package ddo_pkg;

  // Field widths
  localparam int VEL_W  = 16;
  localparam int DT_W   = 16;
  localparam int POS_W  = 32;
  localparam int Q15_W  = 16;

  // Shared multiplier operand and product widths
  localparam int MUL_A_W = 44;
  localparam int MUL_B_W = 18;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

  // CORDIC datapath widths (Q2.30 with headroom, angle with one guard bit)
  localparam int XY_W  = 34;
  localparam int ANG_W = 33;
  localparam int ATAN_W = 30;
  localparam int ATAN_IDX_W = 5;

  localparam int CORDIC_ITERATIONS_DEF = 16;

  localparam logic [15:0] INV_SEP_RESET = 16'd1422;

  // round(2^32 / (2*pi)), applied as two 15-bit halves
  localparam logic [29:0] TURN_SCALE = 30'd683565276;
  localparam logic [14:0] TURN_SCALE_LO = TURN_SCALE[14:0];
  localparam logic [14:0] TURN_SCALE_HI = TURN_SCALE[29:15];

  localparam logic signed [XY_W-1:0]  CORDIC_GAIN  = 34'sd652032874;
  localparam logic signed [ANG_W-1:0] QUARTER_TURN = 33'sd1073741824;
  localparam logic signed [ANG_W-1:0] HALF_TURN    = 33'sd2147483648;

  typedef struct packed {
    logic signed [VEL_W-1:0] left_wheel_vel;
    logic signed [VEL_W-1:0] right_wheel_vel;
    logic        [DT_W-1:0]  tick_dt;
  } in_item_t;

  typedef struct packed {
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic signed [POS_W-1:0] heading;
    logic signed [Q15_W-1:0] quat_z;
    logic signed [Q15_W-1:0] quat_w;
    logic signed [VEL_W-1:0] linear_vel;
    logic signed [POS_W-1:0] angular_vel;
  } out_item_t;

  // CORDIC status and result toward the sequencer
  typedef struct packed {
    logic            valid;
    logic [XY_W-1:0] cos_v;
    logic [XY_W-1:0] sin_v;
  } cordic_res_t;

  // atan(2^-i) as a binary angle, 2^32 = one turn
  function automatic logic [ATAN_W-1:0] atan_entry(input logic [ATAN_IDX_W-1:0] idx);
    case (idx)
      5'd0:  return 30'h20000000;
      5'd1:  return 30'h12E4051E;
      5'd2:  return 30'h09FB385B;
      5'd3:  return 30'h051111D4;
      5'd4:  return 30'h028B0D43;
      5'd5:  return 30'h0145D7E1;
      5'd6:  return 30'h00A2F61E;
      5'd7:  return 30'h00517C55;
      5'd8:  return 30'h0028BE53;
      5'd9:  return 30'h00145F2F;
      5'd10: return 30'h000A2F98;
      5'd11: return 30'h000517CC;
      5'd12: return 30'h00028BE6;
      5'd13: return 30'h000145F3;
      5'd14: return 30'h0000A2FA;
      5'd15: return 30'h0000517D;
      5'd16: return 30'h000028BE;
      5'd17: return 30'h0000145F;
      5'd18: return 30'h00000A30;
      5'd19: return 30'h00000518;
      5'd20: return 30'h0000028C;
      5'd21: return 30'h00000146;
      5'd22: return 30'h000000A3;
      5'd23: return 30'h00000051;
      5'd24: return 30'h00000029;
      5'd25: return 30'h00000014;
      5'd26: return 30'h0000000A;
      5'd27: return 30'h00000005;
      5'd28: return 30'h00000003;
      5'd29: return 30'h00000001;
      default: return 30'h00000000;
    endcase
  endfunction

  // Q2.30 to Q1.15 with round-half-up and saturation
  function automatic logic [Q15_W-1:0] to_q15(input logic signed [XY_W-1:0] v);
    logic signed [XY_W-1:0] t;
    t = (v + 34'sd16384) >>> 15;
    if (t > 34'sd32767) return 16'h7FFF;
    if (t < -34'sd32768) return 16'h8000;
    return t[Q15_W-1:0];
  endfunction

  // Clamp a widened position sum to 32 bits
  function automatic logic [POS_W-1:0] sat_pos(input logic signed [POS_W+2:0] v);
    if (v > 35'sd2147483647) return 32'h7FFF_FFFF;
    if (v < -35'sd2147483648) return 32'h8000_0000;
    return v[POS_W-1:0];
  endfunction

endpackage

>>> rtl/ddo_mul.sv
// Shared signed multiplier with registered product.
module ddo_mul (
  input  logic                                 clk,
  input  logic signed [ddo_pkg::MUL_A_W-1:0]   mul_a,
  input  logic signed [ddo_pkg::MUL_B_W-1:0]   mul_b,
  output logic signed [ddo_pkg::MUL_P_W-1:0]   prod_r
);

  // Product is registered and lands in the cycle after the operands
  always_ff @(posedge clk) begin
    prod_r <= ddo_pkg::MUL_P_W'(mul_a) * ddo_pkg::MUL_P_W'(mul_b);
  end

endmodule

>>> rtl/ddo_cordic.sv
// Iterative rotation-mode CORDIC: one micro-rotation per cycle, gives Q2.30 cos and sin.
module ddo_cordic #(
  parameter int ITERATIONS = ddo_pkg::CORDIC_ITERATIONS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [31:0]               angle,
  output ddo_pkg::cordic_res_t      res
);

  localparam int ITER_W = $clog2(ITERATIONS + 1);

  logic                                busy_r;
  logic                                valid_r;
  logic                                neg_r;
  logic [ITER_W-1:0]                   cnt_r;
  logic signed [ddo_pkg::XY_W-1:0]     x_r;
  logic signed [ddo_pkg::XY_W-1:0]     y_r;
  logic signed [ddo_pkg::ANG_W-1:0]    z_r;

  logic signed [ddo_pkg::ANG_W-1:0]    a_ext;
  logic signed [ddo_pkg::ANG_W-1:0]    z_fold;
  logic                                neg_fold;
  logic signed [ddo_pkg::XY_W-1:0]     xs;
  logic signed [ddo_pkg::XY_W-1:0]     ys;
  logic signed [ddo_pkg::ANG_W-1:0]    atan_v;
  logic signed [ddo_pkg::XY_W-1:0]     x_nxt;
  logic signed [ddo_pkg::XY_W-1:0]     y_nxt;
  logic signed [ddo_pkg::ANG_W-1:0]    z_nxt;
  logic                                last_iter;

  // Fold the start angle into [-1/4, 1/4] turn; a half-turn negates both outputs
  always_comb begin
    a_ext    = ddo_pkg::ANG_W'(signed'(angle));
    z_fold   = a_ext;
    neg_fold = 1'b0;
    if (a_ext > ddo_pkg::QUARTER_TURN) begin
      z_fold   = a_ext - ddo_pkg::HALF_TURN;
      neg_fold = 1'b1;
    end else if (a_ext < -ddo_pkg::QUARTER_TURN) begin
      z_fold   = a_ext + ddo_pkg::HALF_TURN;
      neg_fold = 1'b1;
    end
  end

  // One micro-rotation
  always_comb begin
    xs     = x_r >>> cnt_r;
    ys     = y_r >>> cnt_r;
    atan_v = signed'({3'b000, ddo_pkg::atan_entry(ddo_pkg::ATAN_IDX_W'(cnt_r))});
    if (!z_r[ddo_pkg::ANG_W-1]) begin
      x_nxt = x_r - ys;
      y_nxt = y_r + xs;
      z_nxt = z_r - atan_v;
    end else begin
      x_nxt = x_r + ys;
      y_nxt = y_r - xs;
      z_nxt = z_r + atan_v;
    end
    last_iter = (cnt_r == ITER_W'(ITERATIONS - 1));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      valid_r <= 1'b0;
    end else if (start) begin
      busy_r  <= 1'b1;
      valid_r <= 1'b0;
      cnt_r   <= '0;
      x_r     <= ddo_pkg::CORDIC_GAIN;
      y_r     <= '0;
      z_r     <= z_fold;
      neg_r   <= neg_fold;
    end else if (busy_r) begin
      x_r   <= x_nxt;
      y_r   <= y_nxt;
      z_r   <= z_nxt;
      cnt_r <= cnt_r + 1'b1;
      if (last_iter) begin
        busy_r  <= 1'b0;
        valid_r <= 1'b1;
      end
    end
  end

  // Result holds until the next start
  assign res.valid = valid_r;
  assign res.cos_v = neg_r ? -x_r : x_r;
  assign res.sin_v = neg_r ? -y_r : y_r;

endmodule

>>> rtl/diff_drive_odometry_integrator.sv
// Throughput: one transaction at a time; in_stall stays high until the result is registered,
// set by two passes through the shared iterative CORDIC plus the shared multiplier steps.
// The output register lets the next input be taken while a result waits on out_stall.
// Reset (rst_n, synchronous): pose and heading cleared, inv_wheel_separation = 1422.
// Top level: sequencer driving one shared multiplier and one shared CORDIC unit.
module diff_drive_odometry_integrator #(
  parameter int CORDIC_ITERATIONS = ddo_pkg::CORDIC_ITERATIONS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  ddo_pkg::in_item_t    in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output ddo_pkg::out_item_t   out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [15:0]          cfg_data
);

  typedef enum logic [3:0] {
    S_IDLE, S_ANG, S_KLO, S_KHI, S_WB, S_DTH, S_HEAD, S_CWAIT,
    S_XS, S_XDT, S_YDT, S_YUPD, S_QWAIT
  } state_t;

  state_t                                   state_r;
  logic [15:0]                              inv_r;
  logic signed [ddo_pkg::POS_W-1:0]         x_r;
  logic signed [ddo_pkg::POS_W-1:0]         y_r;
  logic [ddo_pkg::POS_W-1:0]                yaw_r;
  ddo_pkg::in_item_t                        item_r;
  logic signed [ddo_pkg::VEL_W-1:0]         lin_r;
  logic signed [28:0]                       ang_r;
  logic signed [44:0]                       acc_r;
  logic signed [ddo_pkg::MUL_A_W-1:0]       wb_r;
  logic [ddo_pkg::POS_W-1:0]                dth_r;
  logic signed [35:0]                       px_r;
  logic signed [35:0]                       py_r;
  logic                                     out_valid_r;
  ddo_pkg::out_item_t                       out_data_r;

  logic signed [ddo_pkg::MUL_A_W-1:0]       mul_a;
  logic signed [ddo_pkg::MUL_B_W-1:0]       mul_b;
  logic signed [ddo_pkg::MUL_P_W-1:0]       prod_r;
  logic                                     cor_start;
  logic [31:0]                              cor_angle;
  ddo_pkg::cordic_res_t                     cor_res;

  logic signed [ddo_pkg::VEL_W:0]           sum17;
  logic signed [ddo_pkg::VEL_W:0]           diff17;
  logic signed [59:0]                       wb_sum;
  logic [ddo_pkg::POS_W-1:0]                yaw_sum;
  logic signed [33:0]                       step;
  logic signed [ddo_pkg::POS_W+2:0]         x_sum;
  logic signed [ddo_pkg::POS_W+2:0]         y_sum;
  logic                                     out_free;
  logic                                     out_load;

  ddo_mul u_mul (
    .clk    (clk),
    .mul_a  (mul_a),
    .mul_b  (mul_b),
    .prod_r (prod_r)
  );

  ddo_cordic #(
    .ITERATIONS (CORDIC_ITERATIONS)
  ) u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cor_start),
    .angle (cor_angle),
    .res   (cor_res)
  );

  // Datapath helpers
  always_comb begin
    sum17    = 17'(item_r.right_wheel_vel) + 17'(item_r.left_wheel_vel);
    diff17   = 17'(item_r.right_wheel_vel) - 17'(item_r.left_wheel_vel);
    wb_sum   = (60'(signed'(prod_r[44:0])) <<< 15) + 60'(acc_r);
    yaw_sum  = yaw_r + dth_r;
    step     = signed'(prod_r[61:28]);
    x_sum    = 35'(x_r) + 35'(step);
    y_sum    = 35'(y_r) + 35'(step);
    out_free = !out_valid_r || !out_stall;
    out_load = (state_r == S_QWAIT) && cor_res.valid && out_free;
  end

  // Operand select for the shared multiplier and CORDIC start
  always_comb begin
    mul_a     = '0;
    mul_b     = '0;
    cor_start = 1'b0;
    cor_angle = yaw_r;
    case (state_r)
      S_ANG: begin
        mul_a = 44'(diff17);
        mul_b = signed'({2'b00, inv_r});
      end
      S_KLO: begin
        mul_a     = 44'(signed'(prod_r[32:4]));
        mul_b     = signed'({3'b000, ddo_pkg::TURN_SCALE_LO});
        cor_start = 1'b1;
      end
      S_KHI: begin
        mul_a = 44'(ang_r);
        mul_b = signed'({3'b000, ddo_pkg::TURN_SCALE_HI});
      end
      S_DTH: begin
        mul_a = wb_r;
        mul_b = signed'({2'b00, item_r.tick_dt});
      end
      S_CWAIT: begin
        mul_a = 44'(signed'(cor_res.cos_v));
        mul_b = 18'(lin_r);
      end
      S_XS: begin
        mul_a = 44'(signed'(cor_res.sin_v));
        mul_b = 18'(lin_r);
      end
      S_XDT: begin
        mul_a = 44'(px_r);
        mul_b = signed'({2'b00, item_r.tick_dt});
      end
      S_YDT: begin
        mul_a = 44'(py_r);
        mul_b = signed'({2'b00, item_r.tick_dt});
      end
      S_YUPD: begin
        cor_start = 1'b1;
        cor_angle = 32'(signed'(yaw_sum) >>> 1);
      end
      default: begin
        mul_a = '0;
      end
    endcase
  end

  // Sequencer, pose state and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      inv_r       <= ddo_pkg::INV_SEP_RESET;
      x_r         <= '0;
      y_r         <= '0;
      yaw_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        inv_r <= cfg_data;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            item_r  <= in_data;
            state_r <= S_ANG;
          end
        end
        S_ANG: begin
          lin_r   <= sum17[ddo_pkg::VEL_W:1];
          state_r <= S_KLO;
        end
        S_KLO: begin
          ang_r   <= signed'(prod_r[32:4]);
          state_r <= S_KHI;
        end
        S_KHI: begin
          acc_r   <= signed'(prod_r[44:0]);
          state_r <= S_WB;
        end
        S_WB: begin
          wb_r    <= signed'(wb_sum[59:16]);
          state_r <= S_DTH;
        end
        S_DTH: begin
          state_r <= S_HEAD;
        end
        S_HEAD: begin
          dth_r   <= prod_r[47:16];
          state_r <= S_CWAIT;
        end
        S_CWAIT: begin
          if (cor_res.valid) begin
            state_r <= S_XS;
          end
        end
        S_XS: begin
          px_r    <= signed'(prod_r[49:14]);
          state_r <= S_XDT;
        end
        S_XDT: begin
          py_r    <= signed'(prod_r[49:14]);
          state_r <= S_YDT;
        end
        S_YDT: begin
          x_r     <= signed'(ddo_pkg::sat_pos(x_sum));
          state_r <= S_YUPD;
        end
        S_YUPD: begin
          y_r     <= signed'(ddo_pkg::sat_pos(y_sum));
          yaw_r   <= yaw_sum;
          state_r <= S_QWAIT;
        end
        S_QWAIT: begin
          if (out_load) begin
            out_data_r.pos_x        <= x_r;
            out_data_r.pos_y        <= y_r;
            out_data_r.heading      <= signed'(yaw_r);
            out_data_r.quat_z       <= signed'(ddo_pkg::to_q15(signed'(cor_res.sin_v)));
            out_data_r.quat_w       <= signed'(ddo_pkg::to_q15(signed'(cor_res.cos_v)));
            out_data_r.linear_vel   <= lin_r;
            out_data_r.angular_vel  <= 32'(ang_r);
            state_r                 <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
